/* sv/asdp_pkg.sv */
`default_nettype none
package asdp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OFFSET_W   = 17;
    localparam int WORD_W     = 32;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_MODE     = 2'd0,
        CFG_FOURTEEN_BIT     = 2'd1,
        CFG_DOWNSAMPLE_SHIFT = 2'd2,
        CFG_FRAGMENT_BYTES   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TABLE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [1:0]          channel_mode;
        logic                fourteen_bit;
        logic [1:0]          downsample_shift;
        logic [OFFSET_W-1:0] fragment_bytes;
    } t_cfg;

    // one frame after byte selection
    typedef struct packed {
        logic [7:0] left_msb;
        logic [7:0] right_msb;
        logic [7:0] left_lsb;
        logic [7:0] right_lsb;
        logic       end_of_chunk;
    } t_frame;

    function automatic logic is_stereo(input t_cfg c);
        return c.channel_mode[0];
    endfunction

    function automatic logic is_conv(input t_cfg c);
        return c.channel_mode[1] & c.fourteen_bit;
    endfunction

endpackage
`default_nettype wire

/* sv/audio_sample_dma_packer_unit.sv */
// A frame that completes a word passes the front registers, the queue and the output registers.
// Throughput: one item per cycle while o_full is low; a table write takes the memory write port for its cycle.
// The conversion memory has one write and two registered read ports, read on acceptance.
// Reset (synchronous, active low) clears counters, offset, shift words and queues;
// the conversion memory is not cleared and holds garbage until loaded.
`default_nettype none
module audio_sample_dma_packer_unit #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [asdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [asdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic                            i_opcode,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0]   i_left_sample,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0]   i_right_sample,
    input  wire logic                            i_end_of_chunk,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0]   i_table_index,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0]   i_table_value,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output logic [asdp_pkg::OFFSET_W-1:0]        o_byte_offset,
    output logic [asdp_pkg::WORD_W-1:0]          o_left_msb_word,
    output logic [asdp_pkg::WORD_W-1:0]          o_right_msb_word,
    output logic [asdp_pkg::WORD_W-1:0]          o_left_lsb_word,
    output logic [asdp_pkg::WORD_W-1:0]          o_right_lsb_word
);
    import asdp_pkg::*;

    t_cfg   r_cfg;
    logic   fq_push, fq_full, bq_pop, bq_empty;
    t_frame fq_data, bq_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_mode     <= 2'd3;
            r_cfg.fourteen_bit     <= 1'b0;
            r_cfg.downsample_shift <= 2'd0;
            r_cfg.fragment_bytes   <= OFFSET_W'(4096);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CHANNEL_MODE:     r_cfg.channel_mode     <= i_cfg_data[1:0];
                CFG_FOURTEEN_BIT:     r_cfg.fourteen_bit     <= i_cfg_data[0];
                CFG_DOWNSAMPLE_SHIFT: r_cfg.downsample_shift <= i_cfg_data[1:0];
                CFG_FRAGMENT_BYTES:   r_cfg.fragment_bytes   <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    asdp_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_opcode       (i_opcode),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_end_of_chunk (i_end_of_chunk),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .o_q_push       (fq_push),
        .o_q_data       (fq_data),
        .i_q_full       (fq_full)
    );

    asdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (fq_full),
        .i_pop   (bq_pop),
        .o_data  (bq_data),
        .o_empty (bq_empty)
    );

    asdp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (bq_empty),
        .i_q_data         (bq_data),
        .o_q_pop          (bq_pop),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_byte_offset    (o_byte_offset),
        .o_left_msb_word  (o_left_msb_word),
        .o_right_msb_word (o_right_msb_word),
        .o_left_lsb_word  (o_left_lsb_word),
        .o_right_lsb_word (o_right_lsb_word)
    );

endmodule
`default_nettype wire

/* sv/asdp_front.sv */
`default_nettype none
module asdp_front #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire asdp_pkg::t_cfg                i_cfg,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic                          i_opcode,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0] i_left_sample,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0] i_right_sample,
    input  wire logic                          i_end_of_chunk,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0] i_table_index,
    input  wire logic [asdp_pkg::SAMPLE_W-1:0] i_table_value,
    output logic                               o_q_push,
    output asdp_pkg::t_frame                   o_q_data,
    input  wire logic                          i_q_full
);
    import asdp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [SAMPLE_W-1:0] r_mem [TABLE_ENTRIES];

    logic                r_valid, n_valid;
    logic [SAMPLE_W-1:0] r_left, r_right;
    logic                r_eoc;
    logic [SAMPLE_W-1:0] r_rd_left, r_rd_right;

    logic accept, accept_frame, accept_table, advance;

    assign o_full       = r_valid & i_q_full;
    assign accept       = i_push & ~o_full;
    assign accept_frame = accept & (t_opcode'(i_opcode) == OP_FRAME);
    assign accept_table = accept & (t_opcode'(i_opcode) == OP_TABLE);
    assign advance      = r_valid & ~i_q_full;

    // table writes land before any later frame reads its entry
    always_ff @(posedge i_clk) begin
        if (accept_table) begin
            r_mem[i_table_index[IDX_W-1:0]] <= i_table_value;
        end
        if (accept_frame) begin
            r_rd_left  <= r_mem[i_left_sample[IDX_W-1:0]];
            r_rd_right <= r_mem[i_right_sample[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_frame) begin
            r_left  <= i_left_sample;
            r_right <= i_right_sample;
            r_eoc   <= i_end_of_chunk;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept_frame) begin
            n_valid = 1'b1;
        end else if (advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_q_data.end_of_chunk = r_eoc;
        if (is_conv(i_cfg)) begin
            o_q_data.left_msb  = r_rd_left[15:8];
            o_q_data.left_lsb  = r_rd_left[7:0];
            o_q_data.right_msb = r_rd_right[15:8];
            o_q_data.right_lsb = r_rd_right[7:0];
        end else if (i_cfg.channel_mode[1]) begin
            o_q_data.left_msb  = r_left[15:8];
            o_q_data.left_lsb  = 8'd0;
            o_q_data.right_msb = r_right[15:8];
            o_q_data.right_lsb = 8'd0;
        end else begin
            o_q_data.left_msb  = r_left[7:0];
            o_q_data.left_lsb  = 8'd0;
            o_q_data.right_msb = r_right[7:0];
            o_q_data.right_lsb = 8'd0;
        end
    end

    assign o_q_push = advance;

endmodule
`default_nettype wire

/* sv/asdp_queue.sv */
`default_nettype none
module asdp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire asdp_pkg::t_frame i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output asdp_pkg::t_frame      o_data,
    output logic                  o_empty
);
    import asdp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/asdp_back.sv */
`default_nettype none
module asdp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire asdp_pkg::t_cfg                i_cfg,
    input  wire logic                          i_q_empty,
    input  wire asdp_pkg::t_frame              i_q_data,
    output logic                               o_q_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [asdp_pkg::OFFSET_W-1:0]      o_byte_offset,
    output logic [asdp_pkg::WORD_W-1:0]        o_left_msb_word,
    output logic [asdp_pkg::WORD_W-1:0]        o_right_msb_word,
    output logic [asdp_pkg::WORD_W-1:0]        o_left_lsb_word,
    output logic [asdp_pkg::WORD_W-1:0]        o_right_lsb_word
);
    import asdp_pkg::*;

    logic [2:0]          r_phase, n_phase;
    logic [1:0]          r_packed, n_packed;
    logic [OFFSET_W-1:0] r_offset, n_offset, off_adv;
    logic [WORD_W-1:0]   r_lm, r_rm, r_ll, r_rl;
    logic [WORD_W-1:0]   n_lm, n_rm, n_ll, n_rl;
    logic                r_out_valid, n_out_valid;
    logic                stereo, conv, kept, emit, go;
    logic [2:0]          mask;

    assign stereo = is_stereo(i_cfg);
    assign conv   = is_conv(i_cfg);
    assign mask   = 3'((4'd1 << i_cfg.downsample_shift) - 4'd1);
    assign kept   = (r_phase == 3'd0);
    assign emit   = kept & (r_packed == 2'd3);
    // a frame that emits needs the output slot free or being taken
    assign go      = ~i_q_empty & (~emit | ~r_out_valid | i_pop);
    assign o_q_pop = go;
    assign o_empty = ~r_out_valid;

    always_comb begin
        n_lm = r_lm;
        n_rm = r_rm;
        n_ll = r_ll;
        n_rl = r_rl;
        n_packed = r_packed;
        if (kept) begin
            n_lm = {r_lm[WORD_W-9:0], i_q_data.left_msb};
            if (stereo) begin
                n_rm = {r_rm[WORD_W-9:0], i_q_data.right_msb};
            end
            if (conv) begin
                n_ll = {r_ll[WORD_W-9:0], i_q_data.left_lsb};
                if (stereo) begin
                    n_rl = {r_rl[WORD_W-9:0], i_q_data.right_lsb};
                end
            end
            n_packed = r_packed + 2'd1;
        end
        n_phase  = (r_phase + 3'd1) & mask;
        off_adv  = emit ? r_offset + OFFSET_W'(4) : r_offset;
        n_offset = (i_q_data.end_of_chunk && off_adv >= i_cfg.fragment_bytes) ? '0 : off_adv;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (go && emit) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_packed    <= '0;
            r_offset    <= '0;
            r_lm        <= '0;
            r_rm        <= '0;
            r_ll        <= '0;
            r_rl        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (go) begin
                r_phase  <= n_phase;
                r_packed <= n_packed;
                r_offset <= n_offset;
                r_lm     <= n_lm;
                r_rm     <= n_rm;
                r_ll     <= n_ll;
                r_rl     <= n_rl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            o_byte_offset    <= r_offset;
            o_left_msb_word  <= n_lm;
            o_right_msb_word <= stereo ? n_rm : n_lm;
            o_left_lsb_word  <= conv ? n_ll : '0;
            o_right_lsb_word <= conv ? (stereo ? n_rl : n_ll) : '0;
        end
    end

endmodule
`default_nettype wire

/* sv/asdp_checker.sv */
`default_nettype none
module asdp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_push,
    input wire logic                          o_full,
    input wire logic                          o_empty,
    input wire logic                          i_pop,
    input wire logic [asdp_pkg::OFFSET_W-1:0] o_byte_offset,
    input wire logic [asdp_pkg::WORD_W-1:0]   o_left_msb_word
);

    // reset leaves both sides idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not idle after reset");

    // a waiting result is not replaced before it is taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_byte_offset)
                                  && $stable(o_left_msb_word)))
        else $error("result changed while stalled");

    // offsets advance in whole words
    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_byte_offset[1:0] == 2'd0))
        else $error("byte offset not word aligned");

    // a push with no space is refused, so full only follows an earlier push
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_full)) |-> $past(i_push))
        else $error("full rose without a push");

endmodule

bind audio_sample_dma_packer_unit asdp_checker u_asdp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_push          (i_push),
    .o_full          (o_full),
    .o_empty         (o_empty),
    .i_pop           (i_pop),
    .o_byte_offset   (o_byte_offset),
    .o_left_msb_word (o_left_msb_word)
);
`default_nettype wire

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asdp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int TABLE_ENTRIES = 65536;

    typedef struct packed {
        t_opcode     op;
        logic [15:0] left;
        logic [15:0] right;
        logic        eoc;
        logic [15:0] tidx;
        logic [15:0] tval;
    } frame_item_t;

    typedef struct packed {
        logic [16:0] offset;
        logic [31:0] lm;
        logic [31:0] rm;
        logic [31:0] ll;
        logic [31:0] rl;
    } word_set_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_push = 1'b0;
    logic                  o_full;
    logic                  i_opcode = 1'b0;
    logic [SAMPLE_W-1:0]   i_left_sample = '0;
    logic [SAMPLE_W-1:0]   i_right_sample = '0;
    logic                  i_end_of_chunk = 1'b0;
    logic [SAMPLE_W-1:0]   i_table_index = '0;
    logic [SAMPLE_W-1:0]   i_table_value = '0;
    logic                  o_empty;
    logic                  i_pop = 1'b0;
    logic [OFFSET_W-1:0]   o_byte_offset;
    logic [WORD_W-1:0]     o_left_msb_word;
    logic [WORD_W-1:0]     o_right_msb_word;
    logic [WORD_W-1:0]     o_left_lsb_word;
    logic [WORD_W-1:0]     o_right_lsb_word;

    audio_sample_dma_packer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_opcode         (i_opcode),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_end_of_chunk   (i_end_of_chunk),
        .i_table_index    (i_table_index),
        .i_table_value    (i_table_value),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_byte_offset    (o_byte_offset),
        .o_left_msb_word  (o_left_msb_word),
        .o_right_msb_word (o_right_msb_word),
        .o_left_lsb_word  (o_left_lsb_word),
        .o_right_lsb_word (o_right_lsb_word)
    );

    // stimulus side
    frame_item_t   frames_to_send[$];
    logic [15:0]   loaded_idx[$];
    logic [1:0]    gen_mode = 2'd3;
    logic          gen_fourteen = 1'b0;
    bit            quiet = 1'b0;
    int            hold_requests = 0;

    // packer model state
    t_cfg          pk_cfg;
    logic [2:0]    pk_phase;
    logic [31:0]   pk_lm, pk_rm, pk_ll, pk_rl;
    logic [1:0]    pk_count;
    logic [16:0]   pk_offset;
    logic [15:0]   pk_mem [TABLE_ENTRIES];
    word_set_t     words_due[$];

    bit            in_taken = 1'b0;
    int            stall_cycles = 0;
    int            errors = 0;
    int            items_seen = 0;
    int            table_seen = 0;
    int            results_checked = 0;
    int            reg_writes = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] push_byte(input logic [31:0] word, input logic [7:0] b);
        return {word[23:0], b};
    endfunction

    task automatic pack_item(input frame_item_t it);
        logic       stereo, wide, conv;
        logic [3:0] mask, ph_next;
        logic [15:0] lv, rv;
        word_set_t  ws;
        stereo = pk_cfg.channel_mode[0];
        wide   = pk_cfg.channel_mode[1];
        conv   = wide & pk_cfg.fourteen_bit;
        if (it.op == OP_TABLE) begin
            pk_mem[it.tidx] = it.tval;
            return;
        end
        if (pk_phase == 3'd0) begin
            if (conv) begin
                lv = pk_mem[it.left];
                pk_lm = push_byte(pk_lm, lv[15:8]);
                pk_ll = push_byte(pk_ll, lv[7:0]);
                if (stereo) begin
                    rv = pk_mem[it.right];
                    pk_rm = push_byte(pk_rm, rv[15:8]);
                    pk_rl = push_byte(pk_rl, rv[7:0]);
                end
            end else if (wide) begin
                pk_lm = push_byte(pk_lm, it.left[15:8]);
                if (stereo) pk_rm = push_byte(pk_rm, it.right[15:8]);
            end else begin
                pk_lm = push_byte(pk_lm, it.left[7:0]);
                if (stereo) pk_rm = push_byte(pk_rm, it.right[7:0]);
            end
            pk_count = pk_count + 2'd1;
            if (pk_count == 2'd0) begin
                ws.offset = pk_offset;
                ws.lm = pk_lm;
                ws.rm = stereo ? pk_rm : pk_lm;
                ws.ll = conv ? pk_ll : 32'd0;
                ws.rl = conv ? (stereo ? pk_rl : pk_ll) : 32'd0;
                words_due.push_back(ws);
                pk_offset = pk_offset + 17'd4;
            end
        end
        mask = (4'd1 << pk_cfg.downsample_shift) - 4'd1;
        ph_next = {1'b0, pk_phase} + 4'd1;
        pk_phase = ph_next[2:0] & mask[2:0];
        if (it.eoc && pk_offset >= pk_cfg.fragment_bytes) pk_offset = '0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // monitor and model: sample at the rising edge
    always @(posedge i_clk) begin : mon
        word_set_t   want;
        frame_item_t it;
        bit          popped;
        popped = 1'b0;
        if (!i_rst_n) begin
            pk_cfg    = '{channel_mode: 2'd3, fourteen_bit: 1'b0, downsample_shift: 2'd0,
                          fragment_bytes: 17'd4096};
            pk_phase  = '0;
            pk_lm     = '0;
            pk_rm     = '0;
            pk_ll     = '0;
            pk_rl     = '0;
            pk_count  = '0;
            pk_offset = '0;
            in_taken  = 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                popped = 1'b1;
                if (words_due.size() == 0) begin
                    $display("%0t: result with none expected: offset %h, left %h", $time,
                             o_byte_offset, o_left_msb_word);
                    errors++;
                end else begin
                    want = words_due.pop_front();
                    check_field("byte_offset", 32'(want.offset), 32'(o_byte_offset));
                    check_field("left_msb_word", want.lm, o_left_msb_word);
                    check_field("right_msb_word", want.rm, o_right_msb_word);
                    check_field("left_lsb_word", want.ll, o_left_lsb_word);
                    check_field("right_lsb_word", want.rl, o_right_lsb_word);
                    results_checked++;
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CHANNEL_MODE:     pk_cfg.channel_mode = i_cfg_data[1:0];
                    CFG_FOURTEEN_BIT:     pk_cfg.fourteen_bit = i_cfg_data[0];
                    CFG_DOWNSAMPLE_SHIFT: pk_cfg.downsample_shift = i_cfg_data[1:0];
                    CFG_FRAGMENT_BYTES:   pk_cfg.fragment_bytes = i_cfg_data;
                    default: ;
                endcase
            end
            in_taken = i_push && !o_full;
            if (in_taken) begin
                it = '{op: t_opcode'(i_opcode), left: i_left_sample, right: i_right_sample,
                       eoc: i_end_of_chunk, tidx: i_table_index, tval: i_table_value};
                pack_item(it);
                items_seen++;
                if (it.op == OP_TABLE) table_seen++;
            end
            stall_cycles = (in_taken || popped) ? 0 : stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
            $display("FAIL audio_sample_dma_packer_unit");
            $finish;
        end
    end

    // driver: change inputs on the falling edge
    int tx_gap = 0;
    always @(negedge i_clk) begin : drv
        frame_item_t nx;
        if (i_push && !in_taken) begin
            // hold the item until it is taken
        end else if (tx_gap > 0) begin
            tx_gap--;
            i_push <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(1, 8) - 1;
                i_push <= 1'b0;
            end else begin
                nx = frames_to_send.pop_front();
                i_opcode       <= nx.op;
                i_left_sample  <= nx.left;
                i_right_sample <= nx.right;
                i_end_of_chunk <= nx.eoc;
                i_table_index  <= nx.tidx;
                i_table_value  <= nx.tval;
                i_push         <= 1'b1;
            end
        end else begin
            i_push <= 1'b0;
        end
    end

    int rx_hold = 0;
    int rx_gap = 0;
    int hold_seen = 0;
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            rx_hold = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 8) - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [16:0] value);
        logic [16:0] d;
        d = 17'($urandom);
        case (idx)
            CFG_CHANNEL_MODE: begin
                d[1:0] = value[1:0];
                gen_mode = value[1:0];
            end
            CFG_FOURTEEN_BIT: begin
                d[0] = value[0];
                gen_fourteen = value[0];
            end
            CFG_DOWNSAMPLE_SHIFT: d[1:0] = value[1:0];
            default: d = value;
        endcase
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
    endtask

    // block is idle once nothing is queued, pending or in flight
    task automatic wait_drained();
        while (frames_to_send.size() != 0 || i_push || words_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        // in table mode only loaded entries may be looked up
        if (gen_mode[1] && gen_fourteen)
            return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
        return 16'($urandom);
    endfunction

    function automatic void queue_frame(input logic [15:0] l, input logic [15:0] r,
                                        input logic eoc);
        frames_to_send.push_back('{op: OP_FRAME, left: l, right: r, eoc: eoc,
                                   tidx: 16'($urandom), tval: 16'($urandom)});
    endfunction

    function automatic void queue_table(input logic [15:0] idx, input logic [15:0] val);
        frames_to_send.push_back('{op: OP_TABLE, left: 16'($urandom), right: 16'($urandom),
                                   eoc: 1'($urandom), tidx: idx, tval: val});
        loaded_idx.push_back(idx);
    endfunction

    // chunks of frames ending in end_of_chunk, some stray chunk ends, some table writes
    function automatic void queue_chunks(input int n);
        int count, len, k;
        logic [15:0] idx;
        count = 0;
        while (count < n) begin
            len = $urandom_range(1, 40);
            for (k = 0; k < len && count < n; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    idx = ($urandom_range(0, 3) == 0) ?
                          loaded_idx[$urandom_range(0, loaded_idx.size() - 1)] :
                          16'($urandom);
                    queue_table(idx, 16'($urandom));
                    count++;
                end
                queue_frame(pick_sample(), pick_sample(),
                            (k == len - 1) || ($urandom_range(0, 19) == 0));
                count++;
            end
        end
    endfunction

    function automatic logic [16:0] pick_fragment();
        case ($urandom_range(0, 4))
            0:       return 17'd4;
            1:       return 17'd131068;
            2:       return 17'($urandom_range(4, 64));
            3:       return 17'($urandom_range(4, 1024));
            default: return 17'($urandom_range(4, 131068));
        endcase
    endfunction

    initial begin : stim
        int p, k;
        logic [1:0] shift;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // table loads at the index extremes, then plain 16-bit stereo
        queue_table(16'h0000, 16'hFF00);
        queue_table(16'hFFFF, 16'h00FF);
        queue_table(16'h8001, 16'h1234);
        queue_frame(16'hFFFF, 16'h0000, 1'b0);
        queue_frame(16'h0000, 16'hFFFF, 1'b0);
        queue_frame(16'h00FF, 16'hFF00, 1'b0);
        queue_frame(16'h8001, 16'h7FFE, 1'b1);
        wait_drained();

        // table mode, stereo; lookup right after its entry is written
        write_reg(CFG_FOURTEEN_BIT, 17'd1);
        queue_table(16'h1357, 16'hBEEF);
        queue_frame(16'h1357, 16'hFFFF, 1'b0);
        queue_frame(16'h0000, 16'h8001, 1'b0);
        queue_frame(16'hFFFF, 16'h1357, 1'b0);
        queue_frame(16'h8001, 16'h0000, 1'b1);
        wait_drained();

        // table mode, mono
        write_reg(CFG_CHANNEL_MODE, 17'd2);
        for (k = 0; k < 4; k++) queue_frame(pick_sample(), pick_sample(), k == 3);
        wait_drained();

        // mono 8-bit with table bit set, deepest downsample, smallest fragment
        write_reg(CFG_CHANNEL_MODE, 17'd0);
        write_reg(CFG_DOWNSAMPLE_SHIFT, 17'd3);
        write_reg(CFG_FRAGMENT_BYTES, 17'd4);
        queue_frame(16'h00FF, 16'hFFFF, 1'b0);
        queue_frame(16'hFF00, 16'h0000, 1'b0);
        queue_frame(16'h5AA5, 16'hA55A, 1'b1);
        wait_drained();

        // shift lowered while the phase is past the new mask
        write_reg(CFG_DOWNSAMPLE_SHIFT, 17'd1);
        for (k = 0; k < 5; k++) queue_frame(16'($urandom), 16'($urandom), k == 4);
        wait_drained();

        for (p = 0; p < 12; p++) begin
            wait_drained();
            write_reg(CFG_CHANNEL_MODE, (p < 4) ? 17'(p) : 17'($urandom_range(0, 3)));
            write_reg(CFG_FOURTEEN_BIT, 17'($urandom_range(0, 1)));
            shift = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
            if (p == 1) shift = 2'd3;
            if (p == 2) shift = 2'd0;
            write_reg(CFG_DOWNSAMPLE_SHIFT, 17'(shift));
            write_reg(CFG_FRAGMENT_BYTES, (p == 0) ? 17'd4 :
                                          (p == 1) ? 17'd131068 : pick_fragment());
            // receiver stalls long while frames keep coming
            if (p == 2) hold_requests++;
            queue_chunks(90);
        end

        // no idling from here on
        wait_drained();
        quiet = 1'b1;

        // one long chunk at the largest fragment
        write_reg(CFG_CHANNEL_MODE, 17'd0);
        write_reg(CFG_FOURTEEN_BIT, 17'd0);
        write_reg(CFG_DOWNSAMPLE_SHIFT, 17'd0);
        write_reg(CFG_FRAGMENT_BYTES, 17'd131068);
        for (k = 0; k < 40; k++)
            queue_frame(16'($urandom), 16'($urandom), k == 39);
        wait_drained();

        write_reg(CFG_CHANNEL_MODE, 17'd3);
        write_reg(CFG_FOURTEEN_BIT, 17'd1);
        write_reg(CFG_FRAGMENT_BYTES, 17'd16);
        queue_chunks(150);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (words_due.size() != 0) begin
            $display("%0t: %0d expected word sets never arrived", $time, words_due.size());
            errors++;
        end
        $display("Sent %0d items (%0d table writes) across %0d register writes, all modes.",
                 items_seen, table_seen, reg_writes);
        $display("Checked %0d packed word sets incl. fragment wraps; %0d mismatches.",
                 results_checked, errors);
        if (errors == 0) begin
            $display("PASS audio_sample_dma_packer_unit");
        end else begin
            $display("FAIL audio_sample_dma_packer_unit");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/asdp_pkg.sv
sv/asdp_front.sv
sv/asdp_queue.sv
sv/asdp_back.sv
sv/audio_sample_dma_packer_unit.sv
sv/asdp_checker.sv
bench/tb.sv
